// ===== design/rci_pkg.sv =====
// Shared constants and helpers for the ray against circle intersection pipeline.
package rci_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Round a bit count up to whole bytes.
	function automatic int pad8(input int w);
		return ((w + 7) / 8) * 8;
	endfunction

endpackage

// ===== design/ray_circle_intersect_top.sv =====
// Pipelined 2D ray against circle intersection in exact fixed point.
//
//  channel  | dir | payload
//  s_axis   | in  | origin_x, origin_y, dir_x, dir_y, center_x, center_y, radius
//  m_axis   | out | hit, near_t, far_t, saturated
//
// One ray is taken every cycle unless m_axis stalls. The square root gives
// RW = 2*COORD_BITS + FRAC_BITS + 2 root bits, one root bit per stage, and
// the two dividers give NW = 2*COORD_BITS + FRAC_BITS + 4 quotient bits, one
// quotient bit per stage.
// Reset clears the valid bits only. A stall on m_axis freezes the whole pipeline
// and the output register; s_axis_tready is low for exactly those cycles.
module ray_circle_intersect_top #(
	parameter int COORD_BITS = rci_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rci_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// origin_x, origin_y, dir_x, dir_y, center_x, center_y, radius, zero pad
	input  logic [rci_pkg::pad8(7*COORD_BITS-1)-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit, near_t, far_t, saturated, zero pad
	output logic [rci_pkg::pad8(2*COORD_BITS+2)-1:0] m_axis_tdata
);
	import rci_pkg::*;

	localparam int N    = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int INW  = pad8(7*N-1);
	localparam int OUTW = pad8(2*N+2);
	localparam int PW   = N + 1;
	localparam int AW   = 2*N;
	localparam int HW   = 2*N + 2;
	localparam int CW   = 2*N + 3;
	localparam int HA   = HW - 1;
	localparam int CA   = CW - 1;
	localparam int LO   = N + 1;
	localparam int DW   = 4*N + 4;
	localparam int RW   = 2*N + 2 + F;
	localparam int XW   = 2*RW;
	localparam int SR   = RW + 2;
	localparam int HSW  = 2*N + F + 2;
	localparam int NW   = 2*N + F + 4;
	localparam int DR   = AW + 1;

	typedef struct packed {
		logic signed [HSW-1:0] hs;
		logic [AW-1:0]         a;
		logic                  hit;
		logic                  miss;
	} sqm_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic negn;
		logic negf;
	} dvm_t;

	logic adv;
	logic out_valid_q;

	assign adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = out_valid_q;

	// input unpacking
	logic signed [N-1:0] in_ox, in_oy, in_dx, in_dy, in_cx, in_cy;
	logic [N-2:0] in_r;
	assign in_ox = s_axis_tdata[N-1:0];
	assign in_oy = s_axis_tdata[2*N-1:N];
	assign in_dx = s_axis_tdata[3*N-1:2*N];
	assign in_dy = s_axis_tdata[4*N-1:3*N];
	assign in_cx = s_axis_tdata[5*N-1:4*N];
	assign in_cy = s_axis_tdata[6*N-1:5*N];
	assign in_r  = s_axis_tdata[7*N-2:6*N];

	// front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [PW-1:0] px_s1, py_s1;
	logic signed [N-1:0] dx_s1, dy_s1;
	logic [N-2:0] rad_s1;

	logic signed [2*N-1:0] dxdx_s2, dydy_s2;
	logic signed [2*N:0] dxpx_s2, dypy_s2;
	logic signed [2*N+1:0] pxpx_s2, pypy_s2;
	logic [2*N-3:0] rr_s2;

	logic [AW-1:0] a_s3;
	logic signed [HW-1:0] h_s3;
	logic signed [CW-1:0] c_s3;

	logic [AW-1:0] a_s4;
	logic [HA-1:0] habs_s4;
	logic [CA-1:0] cabs_s4;
	logic hneg_s4, cneg_s4, azero_s4;

	logic [2*LO-1:0] p_hll_s5;
	logic [LO+N-1:0] p_hlh_s5;
	logic [2*N-1:0] p_hhh_s5;
	logic [N+LO-1:0] p_alcl_s5, p_alch_s5, p_ahcl_s5, p_ahch_s5;
	logic [AW-1:0] a_s5;
	logic [HA-1:0] habs_s5;
	logic hneg_s5, cneg_s5, azero_s5;

	logic [DW-1:0] hsq_s6, acm_s6;
	logic [AW-1:0] a_s6;
	logic [HA-1:0] habs_s6;
	logic hneg_s6, cneg_s6, azero_s6;

	logic [DW-1:0] disc_w;
	logic [HSW-1:0] hsh_w;
	logic [DW-1:0] disc_s7;
	sqm_t meta_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign disc_w = cneg_s6 ? hsq_s6 + acm_s6 : hsq_s6 - acm_s6;
	assign hsh_w  = HSW'(habs_s6) << F;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= PW'(in_ox) - PW'(in_cx);
			py_s1  <= PW'(in_oy) - PW'(in_cy);
			dx_s1  <= in_dx;
			dy_s1  <= in_dy;
			rad_s1 <= in_r;

			dxdx_s2 <= dx_s1 * dx_s1;
			dydy_s2 <= dy_s1 * dy_s1;
			dxpx_s2 <= dx_s1 * px_s1;
			dypy_s2 <= dy_s1 * py_s1;
			pxpx_s2 <= px_s1 * px_s1;
			pypy_s2 <= py_s1 * py_s1;
			rr_s2   <= rad_s1 * rad_s1;

			a_s3 <= dxdx_s2[AW-1:0] + dydy_s2[AW-1:0];
			h_s3 <= HW'(dxpx_s2) + HW'(dypy_s2);
			c_s3 <= CW'(pxpx_s2) + CW'(pypy_s2) - CW'($signed({1'b0, rr_s2}));

			a_s4     <= a_s3;
			azero_s4 <= (a_s3 == '0);
			hneg_s4  <= h_s3[HW-1];
			cneg_s4  <= c_s3[CW-1];
			habs_s4  <= h_s3[HW-1] ? HA'(-h_s3) : HA'(h_s3);
			cabs_s4  <= c_s3[CW-1] ? CA'(-c_s3) : CA'(c_s3);

			// split the wide squares into narrow partial products
			p_hll_s5  <= habs_s4[LO-1:0] * habs_s4[LO-1:0];
			p_hlh_s5  <= habs_s4[LO-1:0] * habs_s4[HA-1:LO];
			p_hhh_s5  <= habs_s4[HA-1:LO] * habs_s4[HA-1:LO];
			p_alcl_s5 <= a_s4[N-1:0] * cabs_s4[LO-1:0];
			p_alch_s5 <= a_s4[N-1:0] * cabs_s4[CA-1:LO];
			p_ahcl_s5 <= a_s4[AW-1:N] * cabs_s4[LO-1:0];
			p_ahch_s5 <= a_s4[AW-1:N] * cabs_s4[CA-1:LO];
			a_s5      <= a_s4;
			habs_s5   <= habs_s4;
			hneg_s5   <= hneg_s4;
			cneg_s5   <= cneg_s4;
			azero_s5  <= azero_s4;

			hsq_s6 <= (DW'(p_hhh_s5) << (2*LO)) + (DW'(p_hlh_s5) << (LO+1))
				+ DW'(p_hll_s5);
			acm_s6 <= (DW'(p_ahch_s5) << (N+LO)) + (DW'(p_alch_s5) << LO)
				+ (DW'(p_ahcl_s5) << N) + DW'(p_alcl_s5);
			a_s6     <= a_s5;
			habs_s6  <= habs_s5;
			hneg_s6  <= hneg_s5;
			cneg_s6  <= cneg_s5;
			azero_s6 <= azero_s5;

			disc_s7       <= disc_w;
			meta_s7.a     <= a_s6;
			meta_s7.hit   <= hneg_s6 || cneg_s6;
			meta_s7.miss  <= azero_s6 || disc_w[DW-1];
			meta_s7.hs    <= hneg_s6 ? hsh_w : -hsh_w;
		end
	end

	// square root: one root bit per stage
	logic [XW-1:0] sq_x_s [RW];
	logic [SR-1:0] sq_rem_s [RW];
	logic [RW-1:0] sq_root_s [RW];
	sqm_t          sq_meta_s [RW];
	logic [RW-1:0] sq_v_s;

	for (genvar k = 0; k < RW; k++) begin : g_sq
		logic [XW-1:0] xin;
		logic [SR-1:0] rin;
		logic [RW-1:0] qin;
		sqm_t          min;
		logic          vin;
		logic [SR-1:0] rsh;
		logic [SR-1:0] trial;

		if (k == 0) begin : g_first
			assign xin = XW'(disc_s7[DW-2:0]) << (2*F);
			assign rin = '0;
			assign qin = '0;
			assign min = meta_s7;
			assign vin = v_s7;
		end else begin : g_next
			assign xin = sq_x_s[k-1];
			assign rin = sq_rem_s[k-1];
			assign qin = sq_root_s[k-1];
			assign min = sq_meta_s[k-1];
			assign vin = sq_v_s[k-1];
		end

		assign rsh   = {rin[RW-1:0], xin[XW-1:XW-2]};
		assign trial = {qin, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_x_s[k]    <= xin << 2;
				sq_meta_s[k] <= min;
				if (rsh >= trial) begin
					sq_rem_s[k]  <= rsh - trial;
					sq_root_s[k] <= {qin[RW-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= rsh;
					sq_root_s[k] <= {qin[RW-2:0], 1'b0};
				end
			end
		end
	end

	// numerators, then magnitudes for the floor division
	logic signed [NW-1:0] nn_s8, nf_s8;
	logic [AW-1:0] a_s8, a_s9;
	dvm_t dm_s8, dm_s9;
	logic [NW-1:0] mn_s9, mf_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s8 <= sq_v_s[RW-1];
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nn_s8 <= NW'(sq_meta_s[RW-1].hs) - NW'($signed({1'b0, sq_root_s[RW-1]}));
			nf_s8 <= NW'(sq_meta_s[RW-1].hs) + NW'($signed({1'b0, sq_root_s[RW-1]}));
			a_s8  <= sq_meta_s[RW-1].a;
			dm_s8.hit  <= sq_meta_s[RW-1].hit;
			dm_s8.miss <= sq_meta_s[RW-1].miss;
			dm_s8.negn <= 1'b0;
			dm_s8.negf <= 1'b0;

			// a + ~n is a - 1 - n: the magnitude that floors a negative quotient
			mn_s9 <= nn_s8[NW-1] ? NW'(a_s8) + NW'(~nn_s8) : NW'(nn_s8);
			mf_s9 <= nf_s8[NW-1] ? NW'(a_s8) + NW'(~nf_s8) : NW'(nf_s8);
			a_s9  <= a_s8;
			dm_s9.hit  <= dm_s8.hit;
			dm_s9.miss <= dm_s8.miss;
			dm_s9.negn <= nn_s8[NW-1];
			dm_s9.negf <= nf_s8[NW-1];
		end
	end

	// two restoring dividers, one quotient bit per stage
	logic [NW-1:0] dv_nn_s [NW];
	logic [NW-1:0] dv_nf_s [NW];
	logic [DR-1:0] dv_rn_s [NW];
	logic [DR-1:0] dv_rf_s [NW];
	logic [NW-1:0] dv_qn_s [NW];
	logic [NW-1:0] dv_qf_s [NW];
	logic [AW-1:0] dv_a_s [NW];
	dvm_t          dv_m_s [NW];
	logic [NW-1:0] dv_v_s;

	for (genvar k = 0; k < NW; k++) begin : g_dv
		logic [NW-1:0] nni, nfi, qni, qfi;
		logic [DR-1:0] rni, rfi, rsn, rsf;
		logic [AW-1:0] ai;
		dvm_t          mi;
		logic          vi;

		if (k == 0) begin : g_first
			assign nni = mn_s9;
			assign nfi = mf_s9;
			assign rni = '0;
			assign rfi = '0;
			assign qni = '0;
			assign qfi = '0;
			assign ai  = a_s9;
			assign mi  = dm_s9;
			assign vi  = v_s9;
		end else begin : g_next
			assign nni = dv_nn_s[k-1];
			assign nfi = dv_nf_s[k-1];
			assign rni = dv_rn_s[k-1];
			assign rfi = dv_rf_s[k-1];
			assign qni = dv_qn_s[k-1];
			assign qfi = dv_qf_s[k-1];
			assign ai  = dv_a_s[k-1];
			assign mi  = dv_m_s[k-1];
			assign vi  = dv_v_s[k-1];
		end

		assign rsn = {rni[AW-1:0], nni[NW-1]};
		assign rsf = {rfi[AW-1:0], nfi[NW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_nn_s[k] <= nni << 1;
				dv_nf_s[k] <= nfi << 1;
				dv_a_s[k]  <= ai;
				dv_m_s[k]  <= mi;
				if (rsn >= DR'(ai)) begin
					dv_rn_s[k] <= rsn - DR'(ai);
					dv_qn_s[k] <= {qni[NW-2:0], 1'b1};
				end else begin
					dv_rn_s[k] <= rsn;
					dv_qn_s[k] <= {qni[NW-2:0], 1'b0};
				end
				if (rsf >= DR'(ai)) begin
					dv_rf_s[k] <= rsf - DR'(ai);
					dv_qf_s[k] <= {qfi[NW-2:0], 1'b1};
				end else begin
					dv_rf_s[k] <= rsf;
					dv_qf_s[k] <= {qfi[NW-2:0], 1'b0};
				end
			end
		end
	end

	// clamp to the coordinate range
	logic [NW-1:0] qn, qf;
	logic sat_n, sat_f;
	logic [N-1:0] val_n, val_f;
	localparam logic [N-1:0] MAX_V = {1'b0, {(N-1){1'b1}}};
	localparam logic [N-1:0] MIN_V = {1'b1, {(N-1){1'b0}}};

	assign qn = dv_qn_s[NW-1];
	assign qf = dv_qf_s[NW-1];

	always_comb begin
		if (dv_m_s[NW-1].negn) begin
			sat_n = (|qn[NW-1:N]) || (qn[N-1] && (|qn[N-2:0]));
			val_n = sat_n ? MIN_V : -qn[N-1:0];
		end else begin
			sat_n = |qn[NW-1:N-1];
			val_n = sat_n ? MAX_V : qn[N-1:0];
		end
		if (dv_m_s[NW-1].negf) begin
			sat_f = (|qf[NW-1:N]) || (qf[N-1] && (|qf[N-2:0]));
			val_f = sat_f ? MIN_V : -qf[N-1:0];
		end else begin
			sat_f = |qf[NW-1:N-1];
			val_f = sat_f ? MAX_V : qf[N-1:0];
		end
	end

	logic hit_q, sat_q;
	logic [N-1:0] near_q, far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_v_s[NW-1];
		end
	end

	// drop everything to zero when the roots are not real or the direction is zero
	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_m_s[NW-1].miss) begin
				hit_q  <= 1'b0;
				sat_q  <= 1'b0;
				near_q <= '0;
				far_q  <= '0;
			end else begin
				hit_q  <= dv_m_s[NW-1].hit;
				sat_q  <= sat_n || sat_f;
				near_q <= val_n;
				far_q  <= val_f;
			end
		end
	end

	assign m_axis_tdata = OUTW'({sat_q, far_q, near_q, hit_q});

	logic unused_in;
	assign unused_in = ^s_axis_tdata[INW-1:7*N-1] ^ ^disc_s7[DW-1];

`ifndef NO_ASSERTIONS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[N:1]) <= $signed(m_axis_tdata[2*N:N+1]))
		else $error("near_t above far_t");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2*N+1]) |->
		(m_axis_tdata[N:1] == MIN_V || m_axis_tdata[N:1] == MAX_V ||
		m_axis_tdata[2*N:N+1] == MIN_V || m_axis_tdata[2*N:N+1] == MAX_V))
		else $error("saturated without a clamped root");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv_v_s[NW-1]) |=> m_axis_tvalid)
		else $error("finished item lost at output register");
`endif

endmodule

// ===== tb/ray_circle_intersect_checker.sv =====
// Checker for the ray against circle pipeline: predicts each result and compares it.
`timescale 1ns / 1ps
module ray_circle_intersect_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [rci_pkg::pad8(7*rci_pkg::COORD_BITS_DEF-1)-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [rci_pkg::pad8(2*rci_pkg::COORD_BITS_DEF+2)-1:0] m_axis_tdata,
	output int   fail_count,
	output int   pending_count
);

	typedef logic signed [199:0] wide_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] near_t;
		logic [31:0] far_t;
		logic        saturated;
	} hit_result_t;

	hit_result_t expected_hits[$];

	function automatic wide_t floor_sqrt(input wide_t x);
		wide_t root, cand;
		root = 0;
		for (int k = 95; k >= 0; k--) begin
			cand = root | (wide_t'(1) << k);
			if (cand * cand <= x)
				root = cand;
		end
		return root;
	endfunction

	function automatic wide_t floor_div(input wide_t n, input wide_t d);
		wide_t q;
		q = n / d;
		if (n < 0 && q * d != n)
			q = q - 1;
		return q;
	endfunction

	function automatic logic [31:0] clamp_root(input wide_t q, inout logic sat);
		wide_t hi_lim, lo_lim;
		hi_lim = 200'sd2147483647;
		lo_lim = -200'sd2147483648;
		if (q > hi_lim) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (q < lo_lim) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return q[31:0];
	endfunction

	function automatic hit_result_t predict_hit(input logic [223:0] d);
		wide_t ox, oy, dx, dy, cx, cy, rad, px, py, qa, qh, qc, disc, root, hs;
		hit_result_t res;
		logic sat;
		ox  = $signed(d[31:0]);
		oy  = $signed(d[63:32]);
		dx  = $signed(d[95:64]);
		dy  = $signed(d[127:96]);
		cx  = $signed(d[159:128]);
		cy  = $signed(d[191:160]);
		rad = $signed({1'b0, d[222:192]});
		px = ox - cx;
		py = oy - cy;
		qa = dx * dx + dy * dy;
		qh = dx * px + dy * py;
		qc = px * px + py * py - rad * rad;
		disc = qh * qh - qa * qc;
		res = '0;
		sat = 1'b0;
		if (qa == 0 || disc < 0)
			return res;
		root = floor_sqrt(disc <<< 32);
		hs = -(qh <<< 16);
		res.near_t = clamp_root(floor_div(hs - root, qa), sat);
		res.far_t  = clamp_root(floor_div(hs + root, qa), sat);
		res.hit = (qh < 0) || (qc < 0);
		res.saturated = sat;
		return res;
	endfunction

	assign pending_count = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		hit_result_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_hits.push_back(predict_hit(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit       = m_axis_tdata[0];
				got.near_t    = m_axis_tdata[32:1];
				got.far_t     = m_axis_tdata[64:33];
				got.saturated = m_axis_tdata[65];
				if (expected_hits.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.hit != want.hit)
							$error("hit: expected %0d, got %0d", want.hit, got.hit);
						if (got.near_t != want.near_t)
							$error("near_t: expected %0d, got %0d",
								$signed(want.near_t), $signed(got.near_t));
						if (got.far_t != want.far_t)
							$error("far_t: expected %0d, got %0d",
								$signed(want.far_t), $signed(got.far_t));
						if (got.saturated != want.saturated)
							$error("saturated: expected %0d, got %0d",
								want.saturated, got.saturated);
					end
				end
			end
		end
	end

endmodule

// ===== tb/ray_circle_intersect_top_tb.sv =====
// Testbench top: drives rays into the intersection pipeline and gives the verdict.
`timescale 1ns / 1ps
module ray_circle_intersect_top_tb;

	localparam int IN_W  = rci_pkg::pad8(7*rci_pkg::COORD_BITS_DEF-1);
	localparam int OUT_W = rci_pkg::pad8(2*rci_pkg::COORD_BITS_DEF+2);
	localparam int CYCLE_LIMIT = 600000;
	localparam int LATENCY = 176;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	int fail_count, pending_count;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit recv_hold = 0;
	int cycles = 0;

	ray_circle_intersect_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	ray_circle_intersect_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when asked.
	initial begin
		forever begin
			@(negedge clk);
			if (recv_hold) begin
				m_axis_tready <= 1'b0;
				repeat (3 * LATENCY) @(negedge clk);
				recv_hold = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_ray(input logic [31:0] ox, oy, dx, dy, cx, cy,
			input logic [30:0] rad);
		// idle this cycle with the sender's idle share
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {1'($urandom), rad, cy, cx, dy, dx, oy, ox};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] small_coord(input int bits);
		return 32'($signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
	endfunction

	task automatic send_random_ray();
		logic [31:0] ox, oy, dx, dy, cx, cy;
		logic [30:0] rad;
		int shape, bits;
		shape = $urandom_range(9);
		bits = $urandom_range(8, 24);
		cx = small_coord(bits);
		cy = small_coord(bits);
		rad = 31'($urandom_range((1 << (bits - 1)) - 1));
		ox = small_coord(bits);
		oy = small_coord(bits);
		dx = small_coord(bits);
		dy = small_coord(bits);
		case (shape)
			0, 1: begin
				ox = $urandom; oy = $urandom; dx = $urandom; dy = $urandom;
				cx = $urandom; cy = $urandom; rad = 31'($urandom);
			end
			2: begin
				// start close to the centre, inside the circle unless the radius is tiny
				ox = cx + small_coord(4);
				oy = cy + small_coord(4);
			end
			3: begin
				// near-zero direction from far away drives the roots out of range
				dx = small_coord(2);
				dy = small_coord(2);
				ox = $urandom;
			end
			4: begin
				// aim straight at the centre
				dx = cx - ox;
				dy = cy - oy;
			end
			default: ;
		endcase
		send_ray(ox, oy, dx, dy, cx, cy, rad);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed cases
		send_ray(0, 0, 0, 0, 0, 0, 31'h10000);                       // zero direction
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
		send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 31'h7fffffff);
		send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 31'h7fffffff);
		send_ray(0, 32'hffff0000, 32'h10000, 0, 0, 0, 31'h10000);       // tangent
		send_ray(0, 32'h20000, 32'h10000, 0, 0, 0, 31'h10000);          // miss
		send_ray(32'hfffb0000, 0, 32'h10000, 0, 0, 0, 31'h10000);       // ahead
		send_ray(32'h50000, 0, 32'h10000, 0, 0, 0, 31'h10000);          // behind
		send_ray(0, 0, 32'h10000, 32'h10000, 0, 0, 31'h30000);          // inside
		send_ray(32'h10000, 0, 32'h10000, 0, 32'h10000, 0, 0);          // radius zero
		send_ray(32'h80000000, 0, 1, 0, 32'h7fffffff, 0, 31'h7fffffff); // saturate high
		send_ray(32'h7fffffff, 0, 1, 0, 32'h80000000, 0, 31'h7fffffff); // saturate low
		send_ray(0, 0, 32'hffffffff, 0, 32'h7fffffff, 0, 31'h10000);
		send_ray(0, 0, 0, 32'h80000000, 0, 32'h7fffffff, 31'h7fffffff);
		send_ray(32'h12345, 32'h54321, 32'h3, 32'hfffffffd, 0, 0, 31'h100);
		send_ray(0, 0, 32'h10000, 0, 32'h30000, 32'h10000, 31'h10000);  // grazes at x=3
		drain_results();

		send_idle_pct = 38;
		recv_idle_pct = 87;
		repeat (500) send_random_ray();
		drain_results();

		send_idle_pct = 87;
		recv_idle_pct = 38;
		repeat (500) send_random_ray();
		drain_results();

		// long hold-off at the output while rays keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1;
		repeat (500) send_random_ray();
		s_axis_tvalid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
